>>> sv/jsv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// JSON syntax validator package
// Shared types, constants and literal tables for the byte-serial checker.
// ----------------------------------------------------------------------------
package jsv_pkg;

    localparam int MAX_DEPTH = 64;
    localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);
    localparam int LIMIT_W   = 7;
    localparam int CMP_W     = (DEPTH_W > LIMIT_W) ? DEPTH_W : LIMIT_W;
    localparam int POS_W     = 32;
    localparam int STATUS_W  = 4;
    localparam int OUT_W     = 40;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(64);

    typedef enum logic [STATUS_W-1:0] {
        ST_BUSY        = 4'd0,
        ST_VALID       = 4'd1,
        ST_EXP_STRING  = 4'd2,
        ST_BAD_ESC_END = 4'd3,
        ST_BAD_UNICODE = 4'd4,
        ST_CTRL_CHAR   = 4'd5,
        ST_UNTERM_STR  = 4'd6,
        ST_EXP_NUMBER  = 4'd7,
        ST_EXP_FRAC    = 4'd8,
        ST_EXP_EXP     = 4'd9,
        ST_ARR_COMMA   = 4'd10,
        ST_OBJ_COLON   = 4'd11,
        ST_OBJ_COMMA   = 4'd12,
        ST_EXP_VALUE   = 4'd13,
        ST_TRAILING    = 4'd14,
        ST_TOO_DEEP    = 4'd15
    } t_status;

    typedef enum logic [4:0] {
        PH_VALUE,
        PH_ARR_FIRST,
        PH_OBJ_FIRST,
        PH_OBJ_KEY,
        PH_VSTR,
        PH_VSTR_ESC,
        PH_VSTR_HEX,
        PH_KSTR,
        PH_KSTR_ESC,
        PH_KSTR_HEX,
        PH_COLON,
        PH_AFTER,
        PH_NUM_SIGN,
        PH_NUM_ZERO,
        PH_NUM_INT,
        PH_FRAC_FIRST,
        PH_FRAC,
        PH_EXP_SIGN,
        PH_EXP_FIRST,
        PH_EXP,
        PH_LIT
    } t_phase;

    localparam logic [1:0] LIT_TRUE  = 2'd0;
    localparam logic [1:0] LIT_FALSE = 2'd1;
    localparam logic [1:0] LIT_NULL  = 2'd2;

    // Classified text byte as it travels through the queue
    typedef struct packed {
        logic [7:0] byte_val;
        logic       is_ws;
        logic       is_dig;
        logic       is_hex;
        logic       is_ctrl;
        logic       is_zero;
    } t_cls;

    function automatic logic [2:0] lit_len(input logic [1:0] sel);
        logic [2:0] len;
        case (sel)
            LIT_FALSE: len = 3'd5;
            default:   len = 3'd4;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] lit_char(input logic [1:0] sel, input logic [2:0] idx);
        logic [7:0] ch;
        ch = 8'h00;
        case (sel)
            LIT_TRUE: begin
                case (idx)
                    3'd0:    ch = "t";
                    3'd1:    ch = "r";
                    3'd2:    ch = "u";
                    3'd3:    ch = "e";
                    default: ch = 8'h00;
                endcase
            end
            LIT_FALSE: begin
                case (idx)
                    3'd0:    ch = "f";
                    3'd1:    ch = "a";
                    3'd2:    ch = "l";
                    3'd3:    ch = "s";
                    3'd4:    ch = "e";
                    default: ch = 8'h00;
                endcase
            end
            default: begin
                case (idx)
                    3'd0:    ch = "n";
                    3'd1:    ch = "u";
                    3'd2:    ch = "l";
                    3'd3:    ch = "l";
                    default: ch = 8'h00;
                endcase
            end
        endcase
        return ch;
    endfunction

endpackage
`default_nettype wire

>>> sv/jsv_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// JSON validator front end
// Classifies each incoming text byte before it enters the queue.
// ----------------------------------------------------------------------------
module jsv_front (
    input  wire logic [7:0]  i_byte,
    output jsv_pkg::t_cls    o_cls
);

    always_comb begin
        o_cls.byte_val = i_byte;
        o_cls.is_ws    = (i_byte == 8'h20) || (i_byte >= 8'h09 && i_byte <= 8'h0D);
        o_cls.is_dig   = (i_byte >= "0") && (i_byte <= "9");
        o_cls.is_hex   = ((i_byte >= "0") && (i_byte <= "9"))
                       || ((i_byte >= "a") && (i_byte <= "f"))
                       || ((i_byte >= "A") && (i_byte <= "F"));
        o_cls.is_ctrl  = (i_byte < 8'h20);
        o_cls.is_zero  = (i_byte == 8'h00);
    end

endmodule
`default_nettype wire

>>> sv/jsv_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// JSON validator item queue
// Two-entry queue of classified bytes between front and back.
// ----------------------------------------------------------------------------
module jsv_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire jsv_pkg::t_cls  i_data,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_valid,
    output jsv_pkg::t_cls       o_data
);

    jsv_pkg::t_cls r_mem [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= ~r_wp;
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule
`default_nettype wire

>>> sv/jsv_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// JSON validator back end
// Grammar state machine, container stack, sticky error and result register.
// ----------------------------------------------------------------------------
module jsv_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [jsv_pkg::LIMIT_W-1:0]   i_cfg_wr_data,
    input  wire logic                          i_q_valid,
    input  wire jsv_pkg::t_cls                 i_q_data,
    output logic                               o_q_pop,
    output logic                               o_m_valid,
    input  wire logic                          i_m_ready,
    output logic [jsv_pkg::STATUS_W-1:0]       o_m_status,
    output logic [jsv_pkg::POS_W-1:0]          o_m_pos
);

    localparam int MD = jsv_pkg::MAX_DEPTH;
    localparam int DW = jsv_pkg::DEPTH_W;

    jsv_pkg::t_phase               r_phase, n_phase;
    logic [DW-1:0]                 r_depth, n_depth;
    logic [MD-1:0]                 r_stack, n_stack;
    logic [2:0]                    r_sub, n_sub;
    logic [1:0]                    r_lit, n_lit;
    jsv_pkg::t_status              r_sticky;
    logic [jsv_pkg::POS_W-1:0]     r_pos;
    logic [jsv_pkg::LIMIT_W-1:0]   r_limit;
    logic                          r_m_valid;
    logic [jsv_pkg::STATUS_W-1:0]  r_m_status;
    logic [jsv_pkg::POS_W-1:0]     r_m_pos;

    logic             fire;
    logic [7:0]       b;
    logic             do_push, do_pop, push_kind;
    jsv_pkg::t_status proc_status;
    logic             open_ok;
    logic             top;

    // start-of-value decode
    jsv_pkg::t_phase  sv_phase;
    jsv_pkg::t_status sv_status;
    logic             sv_push, sv_kind, sv_is_lit;
    logic [1:0]       sv_lit;

    // after-value decode
    jsv_pkg::t_phase  av_phase;
    jsv_pkg::t_status av_status;
    logic             av_pop;

    // literal match
    logic [1:0]       lit_sel;
    logic             lit_ok, lit_last;

    assign b        = i_q_data.byte_val;
    assign o_q_pop  = fire;
    assign fire     = i_q_valid && (!r_m_valid || i_m_ready);
    assign top      = r_stack[0];
    assign open_ok  = (r_depth < DW'(MD))
                    && (jsv_pkg::CMP_W'(r_depth) < jsv_pkg::CMP_W'(r_limit));

    assign lit_sel  = (r_lit == 2'd3) ? jsv_pkg::LIT_NULL : r_lit;
    assign lit_ok   = (r_sub < jsv_pkg::lit_len(lit_sel))
                    && (b == jsv_pkg::lit_char(lit_sel, r_sub));
    assign lit_last = ((r_sub + 3'd1) >= jsv_pkg::lit_len(lit_sel));

    always_comb begin
        sv_phase  = r_phase;
        sv_status = jsv_pkg::ST_BUSY;
        sv_push   = 1'b0;
        sv_kind   = 1'b0;
        sv_is_lit = 1'b0;
        sv_lit    = jsv_pkg::LIT_TRUE;
        if (b == "\"") begin
            sv_phase = jsv_pkg::PH_VSTR;
        end else if (b == "{" || b == "[") begin
            sv_kind = (b == "{");
            if (open_ok) begin
                sv_push  = 1'b1;
                sv_phase = (b == "{") ? jsv_pkg::PH_OBJ_FIRST : jsv_pkg::PH_ARR_FIRST;
            end else begin
                sv_status = jsv_pkg::ST_TOO_DEEP;
            end
        end else if (b == "-") begin
            sv_phase = jsv_pkg::PH_NUM_SIGN;
        end else if (b == "0") begin
            sv_phase = jsv_pkg::PH_NUM_ZERO;
        end else if (i_q_data.is_dig) begin
            sv_phase = jsv_pkg::PH_NUM_INT;
        end else if (b == "t" || b == "f" || b == "n") begin
            sv_phase  = jsv_pkg::PH_LIT;
            sv_is_lit = 1'b1;
            sv_lit    = (b == "t") ? jsv_pkg::LIT_TRUE
                      : ((b == "f") ? jsv_pkg::LIT_FALSE : jsv_pkg::LIT_NULL);
        end else begin
            sv_status = jsv_pkg::ST_EXP_VALUE;
        end
    end

    always_comb begin
        av_phase  = jsv_pkg::PH_AFTER;
        av_status = jsv_pkg::ST_BUSY;
        av_pop    = 1'b0;
        if (i_q_data.is_ws) begin
            av_status = jsv_pkg::ST_BUSY;
        end else if (r_depth == '0) begin
            av_status = i_q_data.is_zero ? jsv_pkg::ST_VALID : jsv_pkg::ST_TRAILING;
        end else if (b == (top ? 8'h7D : 8'h5D)) begin
            av_pop = 1'b1;
        end else if (b == ",") begin
            av_phase = top ? jsv_pkg::PH_OBJ_KEY : jsv_pkg::PH_VALUE;
        end else begin
            av_status = top ? jsv_pkg::ST_OBJ_COMMA : jsv_pkg::ST_ARR_COMMA;
        end
    end

    // Next-state block
    always_comb begin
        n_phase   = r_phase;
        n_sub     = r_sub;
        n_lit     = r_lit;
        do_push   = 1'b0;
        do_pop    = 1'b0;
        push_kind = sv_kind;
        case (r_phase)
            jsv_pkg::PH_VALUE: begin
                if (!i_q_data.is_ws) begin
                    n_phase = sv_phase;
                    do_push = sv_push;
                    if (sv_is_lit) begin
                        n_lit = sv_lit;
                        n_sub = 3'd1;
                    end
                end
            end
            jsv_pkg::PH_ARR_FIRST: begin
                if (!i_q_data.is_ws) begin
                    if (b == "]") begin
                        do_pop  = 1'b1;
                        n_phase = jsv_pkg::PH_AFTER;
                    end else begin
                        n_phase = sv_phase;
                        do_push = sv_push;
                        if (sv_is_lit) begin
                            n_lit = sv_lit;
                            n_sub = 3'd1;
                        end
                    end
                end
            end
            jsv_pkg::PH_OBJ_FIRST, jsv_pkg::PH_OBJ_KEY: begin
                if (!i_q_data.is_ws) begin
                    if (r_phase == jsv_pkg::PH_OBJ_FIRST && b == "}") begin
                        do_pop  = 1'b1;
                        n_phase = jsv_pkg::PH_AFTER;
                    end else if (b == "\"") begin
                        n_phase = jsv_pkg::PH_KSTR;
                    end
                end
            end
            jsv_pkg::PH_VSTR, jsv_pkg::PH_KSTR: begin
                if (b == "\"") begin
                    n_phase = (r_phase == jsv_pkg::PH_VSTR) ? jsv_pkg::PH_AFTER
                                                            : jsv_pkg::PH_COLON;
                end else if (b == "\\") begin
                    n_phase = (r_phase == jsv_pkg::PH_VSTR) ? jsv_pkg::PH_VSTR_ESC
                                                            : jsv_pkg::PH_KSTR_ESC;
                end
            end
            jsv_pkg::PH_VSTR_ESC, jsv_pkg::PH_KSTR_ESC: begin
                if (!i_q_data.is_zero) begin
                    if (b == "u") begin
                        n_sub   = 3'd0;
                        n_phase = (r_phase == jsv_pkg::PH_VSTR_ESC) ? jsv_pkg::PH_VSTR_HEX
                                                                    : jsv_pkg::PH_KSTR_HEX;
                    end else begin
                        n_phase = (r_phase == jsv_pkg::PH_VSTR_ESC) ? jsv_pkg::PH_VSTR
                                                                    : jsv_pkg::PH_KSTR;
                    end
                end
            end
            jsv_pkg::PH_VSTR_HEX, jsv_pkg::PH_KSTR_HEX: begin
                if (i_q_data.is_hex) begin
                    if (r_sub >= 3'd3) begin
                        n_sub   = 3'd0;
                        n_phase = (r_phase == jsv_pkg::PH_VSTR_HEX) ? jsv_pkg::PH_VSTR
                                                                    : jsv_pkg::PH_KSTR;
                    end else begin
                        n_sub = r_sub + 3'd1;
                    end
                end
            end
            jsv_pkg::PH_COLON: begin
                if (b == ":") begin
                    n_phase = jsv_pkg::PH_VALUE;
                end
            end
            jsv_pkg::PH_AFTER: begin
                n_phase = av_phase;
                do_pop  = av_pop;
            end
            jsv_pkg::PH_NUM_SIGN: begin
                if (b == "0") begin
                    n_phase = jsv_pkg::PH_NUM_ZERO;
                end else if (i_q_data.is_dig) begin
                    n_phase = jsv_pkg::PH_NUM_INT;
                end
            end
            jsv_pkg::PH_NUM_ZERO, jsv_pkg::PH_NUM_INT: begin
                if (r_phase == jsv_pkg::PH_NUM_INT && i_q_data.is_dig) begin
                    n_phase = r_phase;
                end else if (b == ".") begin
                    n_phase = jsv_pkg::PH_FRAC_FIRST;
                end else if (b == "e" || b == "E") begin
                    n_phase = jsv_pkg::PH_EXP_SIGN;
                end else begin
                    n_phase = av_phase;
                    do_pop  = av_pop;
                end
            end
            jsv_pkg::PH_FRAC_FIRST: begin
                if (i_q_data.is_dig) begin
                    n_phase = jsv_pkg::PH_FRAC;
                end
            end
            jsv_pkg::PH_FRAC: begin
                if (i_q_data.is_dig) begin
                    n_phase = r_phase;
                end else if (b == "e" || b == "E") begin
                    n_phase = jsv_pkg::PH_EXP_SIGN;
                end else begin
                    n_phase = av_phase;
                    do_pop  = av_pop;
                end
            end
            jsv_pkg::PH_EXP_SIGN: begin
                if (b == "+" || b == "-") begin
                    n_phase = jsv_pkg::PH_EXP_FIRST;
                end else if (i_q_data.is_dig) begin
                    n_phase = jsv_pkg::PH_EXP;
                end
            end
            jsv_pkg::PH_EXP_FIRST: begin
                if (i_q_data.is_dig) begin
                    n_phase = jsv_pkg::PH_EXP;
                end
            end
            jsv_pkg::PH_EXP: begin
                if (!i_q_data.is_dig) begin
                    n_phase = av_phase;
                    do_pop  = av_pop;
                end
            end
            jsv_pkg::PH_LIT: begin
                if (lit_ok) begin
                    if (lit_last) begin
                        n_sub   = 3'd0;
                        n_phase = jsv_pkg::PH_AFTER;
                    end else begin
                        n_sub = r_sub + 3'd1;
                    end
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
    end

    // Output block: status the grammar gives for this byte
    always_comb begin
        proc_status = jsv_pkg::ST_BUSY;
        case (r_phase)
            jsv_pkg::PH_VALUE: begin
                if (!i_q_data.is_ws) begin
                    proc_status = sv_status;
                end
            end
            jsv_pkg::PH_ARR_FIRST: begin
                if (!i_q_data.is_ws && b != "]") begin
                    proc_status = sv_status;
                end
            end
            jsv_pkg::PH_OBJ_FIRST, jsv_pkg::PH_OBJ_KEY: begin
                if (!i_q_data.is_ws && b != "\""
                    && !(r_phase == jsv_pkg::PH_OBJ_FIRST && b == "}")) begin
                    proc_status = jsv_pkg::ST_EXP_STRING;
                end
            end
            jsv_pkg::PH_VSTR, jsv_pkg::PH_KSTR: begin
                if (i_q_data.is_zero) begin
                    proc_status = jsv_pkg::ST_UNTERM_STR;
                end else if (i_q_data.is_ctrl) begin
                    proc_status = jsv_pkg::ST_CTRL_CHAR;
                end
            end
            jsv_pkg::PH_VSTR_ESC, jsv_pkg::PH_KSTR_ESC: begin
                if (i_q_data.is_zero) begin
                    proc_status = jsv_pkg::ST_BAD_ESC_END;
                end
            end
            jsv_pkg::PH_VSTR_HEX, jsv_pkg::PH_KSTR_HEX: begin
                if (!i_q_data.is_hex) begin
                    proc_status = jsv_pkg::ST_BAD_UNICODE;
                end
            end
            jsv_pkg::PH_COLON: begin
                if (!i_q_data.is_ws && b != ":") begin
                    proc_status = jsv_pkg::ST_OBJ_COLON;
                end
            end
            jsv_pkg::PH_AFTER: begin
                proc_status = av_status;
            end
            jsv_pkg::PH_NUM_SIGN: begin
                if (!i_q_data.is_dig) begin
                    proc_status = jsv_pkg::ST_EXP_NUMBER;
                end
            end
            jsv_pkg::PH_NUM_ZERO, jsv_pkg::PH_NUM_INT: begin
                if (!(r_phase == jsv_pkg::PH_NUM_INT && i_q_data.is_dig)
                    && b != "." && b != "e" && b != "E") begin
                    proc_status = av_status;
                end
            end
            jsv_pkg::PH_FRAC_FIRST: begin
                if (!i_q_data.is_dig) begin
                    proc_status = jsv_pkg::ST_EXP_FRAC;
                end
            end
            jsv_pkg::PH_FRAC: begin
                if (!i_q_data.is_dig && b != "e" && b != "E") begin
                    proc_status = av_status;
                end
            end
            jsv_pkg::PH_EXP_SIGN: begin
                if (!i_q_data.is_dig && b != "+" && b != "-") begin
                    proc_status = jsv_pkg::ST_EXP_EXP;
                end
            end
            jsv_pkg::PH_EXP_FIRST: begin
                if (!i_q_data.is_dig) begin
                    proc_status = jsv_pkg::ST_EXP_EXP;
                end
            end
            jsv_pkg::PH_EXP: begin
                if (!i_q_data.is_dig) begin
                    proc_status = av_status;
                end
            end
            jsv_pkg::PH_LIT: begin
                if (!lit_ok) begin
                    proc_status = jsv_pkg::ST_EXP_VALUE;
                end
            end
            default: begin
                proc_status = jsv_pkg::ST_EXP_VALUE;
            end
        endcase
    end

    // Stack as a shift line: entry 0 is always the innermost container
    always_comb begin
        n_depth = r_depth;
        n_stack = r_stack;
        if (do_push) begin
            n_depth = r_depth + DW'(1);
            for (int i = 0; i < MD; i++) begin
                n_stack[i] = (i == 0) ? push_kind : r_stack[(i == 0) ? 0 : i - 1];
            end
        end else if (do_pop) begin
            n_depth = r_depth - DW'(1);
            for (int i = 0; i < MD; i++) begin
                n_stack[i] = (i == MD - 1) ? 1'b0 : r_stack[(i == MD - 1) ? i : i + 1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= jsv_pkg::PH_VALUE;
            r_depth   <= '0;
            r_stack   <= '0;
            r_sub     <= 3'd0;
            r_lit     <= jsv_pkg::LIT_TRUE;
            r_sticky  <= jsv_pkg::ST_BUSY;
            r_pos     <= '0;
            r_limit   <= jsv_pkg::LIMIT_RESET;
            r_m_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_limit <= i_cfg_wr_data;
            end
            if (i_m_ready) begin
                r_m_valid <= 1'b0;
            end
            if (fire) begin
                r_m_valid <= 1'b1;
                r_m_pos   <= r_pos;
                if (i_q_data.is_zero) begin
                    // end of document: report, then re-arm
                    r_m_status <= (r_sticky != jsv_pkg::ST_BUSY) ? r_sticky : proc_status;
                    r_phase    <= jsv_pkg::PH_VALUE;
                    r_depth    <= '0;
                    r_stack    <= '0;
                    r_sub      <= 3'd0;
                    r_lit      <= jsv_pkg::LIT_TRUE;
                    r_sticky   <= jsv_pkg::ST_BUSY;
                    r_pos      <= '0;
                end else begin
                    if (r_pos != '1) begin
                        r_pos <= r_pos + jsv_pkg::POS_W'(1);
                    end
                    if (r_sticky == jsv_pkg::ST_BUSY) begin
                        r_phase    <= n_phase;
                        r_depth    <= n_depth;
                        r_stack    <= n_stack;
                        r_sub      <= n_sub;
                        r_lit      <= n_lit;
                        r_sticky   <= proc_status;
                        r_m_status <= proc_status;
                    end else begin
                        r_m_status <= r_sticky;
                    end
                end
            end
        end
    end

    assign o_m_valid  = r_m_valid;
    assign o_m_status = r_m_status;
    assign o_m_pos    = r_m_pos;

endmodule
`default_nettype wire

>>> sv/json_syntax_validator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// JSON syntax validator
// Checks JSON text one byte per item; a zero byte ends each document.
// ----------------------------------------------------------------------------
// Path: an accepted byte is written to a queue slot, then the back end
//   registers its result in the result register, which drives result valid.
// Throughput: one byte per cycle while the result stream is ready, set by the
//   grammar step in the back end, which updates the phase and the container stack.
// Reset: synchronous, active low; clears all parse state, the queue and the
//   result slot, and sets depth_limit to 64. No clearing pass is needed.
// ----------------------------------------------------------------------------
module json_syntax_validator_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration: depth_limit
    input  wire logic        i_cfg_wr_en,
    input  wire logic [6:0]  i_cfg_wr_data,
    // text byte stream
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] text_byte
    // result stream
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [39:0]      o_m_axis_tdata    // [3:0] status, [35:4] byte_position,
                                               // [39:36] zero
);

    jsv_pkg::t_cls                    front_cls;
    jsv_pkg::t_cls                    q_data;
    logic                             q_full;
    logic                             q_valid;
    logic                             q_pop;
    logic [jsv_pkg::STATUS_W-1:0]     m_status;
    logic [jsv_pkg::POS_W-1:0]        m_pos;

    // Front: classify each byte as it arrives
    jsv_front u_front (
        .i_byte (i_s_axis_tdata),
        .o_cls  (front_cls)
    );

    // Queue: lets the input keep flowing while a result waits downstream
    jsv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_s_axis_tvalid),
        .i_data  (front_cls),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    assign o_s_axis_tready = !q_full;

    // Back: run the grammar, hold the stack and drive the result register
    jsv_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_q_valid     (q_valid),
        .i_q_data      (q_data),
        .o_q_pop       (q_pop),
        .o_m_valid     (o_m_axis_tvalid),
        .i_m_ready     (i_m_axis_tready),
        .o_m_status    (m_status),
        .o_m_pos       (m_pos)
    );

    // Pack the result item, status in the lowest bits
    assign o_m_axis_tdata = {4'd0, m_pos, m_status};

endmodule
`default_nettype wire
